FILE: rtl/ptls_pkg.sv
// ----------------------------------------------------------------------------
// ptls_pkg
// Shared types, constants and the arctangent table of the scan binner.
// ----------------------------------------------------------------------------
package ptls_pkg;

	localparam int NUM_BINS       = 1620;
	localparam int BIN_W          = 11;
	localparam int RANGE_W        = 18;
	localparam int COORD_BITS_DEF = 18;
	localparam int CORDIC_STEPS   = 30;
	localparam int ACC_W          = 34;
	localparam int PRESCALE_SH    = 24;
	localparam int ANG_W          = 32;
	localparam int BIN_MUL_W      = 11;

	localparam logic signed [ACC_W-1:0] SPAN_LIMIT   = 34'sd1932735283;
	localparam logic signed [ACC_W-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic [BIN_MUL_W-1:0]    BINS_PER_TURN = 11'd1800;
	localparam logic [RANGE_W-1:0]      EMPTY_RANGE  = 18'd81000;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_SPAN    = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CORDIC,
		S_BIN,
		S_RDMEM,
		S_CMP,
		S_SQRT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             load;
		logic             cordic;
		logic             bin_calc;
		logic             mem_rd;
		logic             mem_upd;
		logic             clr_wr;
		logic             sqrt_step;
		logic             out_load;
		logic [BIN_W-1:0] cnt;
	} ptls_cmd_t;

	typedef struct packed {
		logic span_out;
	} ptls_sts_t;

	function automatic logic [ANG_W-1:0] atan_lut(input logic [4:0] i);
		logic [ANG_W-1:0] t;
		unique case (i)
			5'd0:  t = 32'h20000000;
			5'd1:  t = 32'h12E4051D;
			5'd2:  t = 32'h09FB385B;
			5'd3:  t = 32'h051111D4;
			5'd4:  t = 32'h028B0D43;
			5'd5:  t = 32'h0145D7E1;
			5'd6:  t = 32'h00A2F61E;
			5'd7:  t = 32'h00517C55;
			5'd8:  t = 32'h0028BE53;
			5'd9:  t = 32'h00145F2E;
			5'd10: t = 32'h000A2F98;
			5'd11: t = 32'h000517CC;
			5'd12: t = 32'h00028BE6;
			5'd13: t = 32'h000145F3;
			5'd14: t = 32'h0000A2F9;
			5'd15: t = 32'h0000517C;
			5'd16: t = 32'h000028BE;
			5'd17: t = 32'h0000145F;
			5'd18: t = 32'h00000A2F;
			5'd19: t = 32'h00000517;
			5'd20: t = 32'h0000028B;
			5'd21: t = 32'h00000145;
			5'd22: t = 32'h000000A2;
			5'd23: t = 32'h00000051;
			5'd24: t = 32'h00000028;
			5'd25: t = 32'h00000014;
			5'd26: t = 32'h0000000A;
			5'd27: t = 32'h00000005;
			5'd28: t = 32'h00000002;
			5'd29: t = 32'h00000001;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/ptls_ctrl.sv
// ----------------------------------------------------------------------------
// ptls_ctrl
// Sequencer of the scan binner: clearing sweep, bearing, bin update, sqrt.
// ----------------------------------------------------------------------------
module ptls_ctrl import ptls_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      in_op,
	input  logic      in_point_valid,
	output logic      out_valid,
	input  logic      out_ready,
	input  ptls_sts_t sts,
	output ptls_cmd_t cmd
);

	state_t           state_q, state_d;
	logic [BIN_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;
	logic             op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			op_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cmd.load)
				op_q <= in_op;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = '0;
		cmd     = '0;
		cmd.cnt = cnt_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (cnt_q == BIN_W'(NUM_BINS - 1))
					state_d = S_IDLE;
				else
					cnt_d = cnt_q + 1'b1;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_op)
						state_d = S_RDMEM;
					else if (!in_point_valid)
						state_d = S_DONE;
					else
						state_d = S_CORDIC;
				end
			end
			S_CORDIC: begin
				cmd.cordic = 1'b1;
				if (cnt_q == BIN_W'(CORDIC_STEPS - 1))
					state_d = S_BIN;
				else
					cnt_d = cnt_q + 1'b1;
			end
			S_BIN: begin
				cmd.bin_calc = 1'b1;
				state_d = sts.span_out ? S_DONE : S_RDMEM;
			end
			S_RDMEM: begin
				cmd.mem_rd = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.mem_upd = 1'b1;
				state_d = op_q ? S_SQRT : S_DONE;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == BIN_W'(COORD_BITS - 1))
					state_d = S_DONE;
				else
					cnt_d = cnt_q + 1'b1;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/ptls_dp.sv
// ----------------------------------------------------------------------------
// ptls_dp
// Datapath: cordic bearing, squared range, bin memory, bitwise square root.
// ----------------------------------------------------------------------------
module ptls_dp import ptls_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ptls_cmd_t                    cmd,
	output ptls_sts_t                    sts,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         op,
	input  logic signed [COORD_BITS-1:0] x_mm,
	input  logic signed [COORD_BITS-1:0] y_mm,
	input  logic                         point_valid,
	input  logic [BIN_W-1:0]             bin_index,
	output logic [1:0]                   status,
	output logic [BIN_W-1:0]             bin,
	output logic [RANGE_W-1:0]           range_mm,
	output logic                         bin_filled
);

	localparam int W      = COORD_BITS + 27;
	localparam int R2W    = 2 * COORD_BITS;
	localparam int SW     = 2 * COORD_BITS + 1;
	localparam int EXTW   = (COORD_BITS > RANGE_W) ? COORD_BITS : RANGE_W;
	localparam int PROD_W = ANG_W + BIN_MUL_W;
	localparam int SHW    = BIN_W + 1;

	logic                         keep_nearest_q;
	logic                         op_q, pv_q, origin_q, span_q, filled_q;
	logic signed [COORD_BITS-1:0] x_q, y_q;
	logic [BIN_W-1:0]             idx_q;
	logic signed [W-1:0]          cx_q, cy_q;
	logic signed [ACC_W-1:0]      acc_q;
	logic signed [R2W-1:0]        xsq_q;
	logic [R2W-1:0]               r2_q;
	logic [PROD_W-1:0]            prod_q;
	logic [SW-1:0]                rem_q, res_q;
	logic [R2W:0]                 mem_q [NUM_BINS];
	logic [R2W:0]                 rd_q;

	// load-time pre-rotation into the right half plane
	logic signed [W-1:0] xs, ys;
	assign xs = W'(x_mm) <<< PRESCALE_SH;
	assign ys = W'(y_mm) <<< PRESCALE_SH;

	logic [4:0]              step;
	logic signed [W-1:0]     dx, dy;
	logic signed [ACC_W-1:0] tv;
	assign step = cmd.cnt[4:0];
	assign dx   = cy_q >>> step;
	assign dy   = cx_q >>> step;
	assign tv   = ACC_W'(atan_lut(step));

	logic signed [R2W-1:0] ysq;
	assign ysq = y_q * y_q;

	logic signed [ACC_W-1:0] acc_eff, acc_off;
	assign acc_eff      = origin_q ? '0 : acc_q;
	assign acc_off      = acc_eff + SPAN_LIMIT;
	assign sts.span_out = (acc_eff < -SPAN_LIMIT) || (acc_eff > SPAN_LIMIT);

	logic [BIN_W-1:0] bin_raw, bin_cl;
	assign bin_raw = prod_q[PROD_W-1:ANG_W];
	assign bin_cl  = (bin_raw >= BIN_W'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1) : bin_raw;

	logic             oob;
	logic [BIN_W-1:0] rd_addr;
	assign oob     = idx_q >= BIN_W'(NUM_BINS);
	assign rd_addr = op_q ? (oob ? '0 : idx_q) : bin_cl;

	logic             hit, better;
	logic             we;
	logic [BIN_W-1:0] wa;
	logic [R2W:0]     wd;
	assign hit    = rd_q[R2W];
	assign better = keep_nearest_q ? (r2_q < rd_q[R2W-1:0]) : (r2_q > rd_q[R2W-1:0]);

	always_comb begin
		we = 1'b0;
		wa = rd_addr;
		wd = {1'b1, r2_q};
		if (cmd.clr_wr) begin
			we = 1'b1;
			wa = cmd.cnt;
			wd = '0;
		end else if (cmd.mem_upd) begin
			if (op_q) begin
				we = !oob && hit;
				wd = '0;
			end else begin
				we = !hit || better;
			end
		end
	end

	// square root, two bits of the radicand per step
	logic [SHW-1:0] sh;
	logic [SW-1:0]  sq_bit, trial;
	assign sh     = SHW'(2 * (COORD_BITS - 1)) - {cmd.cnt, 1'b0};
	assign sq_bit = SW'(1) << sh;
	assign trial  = res_q + sq_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			keep_nearest_q <= 1'b1;
		else if (cfg_we)
			keep_nearest_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[wa] <= wd;
		if (cmd.mem_rd)
			rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			pv_q     <= point_valid;
			x_q      <= x_mm;
			y_q      <= y_mm;
			idx_q    <= bin_index;
			origin_q <= (x_mm == '0) && (y_mm == '0);
			span_q   <= 1'b0;
			filled_q <= 1'b0;
			if (x_mm < 0) begin
				if (y_mm >= 0) begin
					cx_q  <= ys;
					cy_q  <= -xs;
					acc_q <= QUARTER_TURN;
				end else begin
					cx_q  <= -ys;
					cy_q  <= xs;
					acc_q <= -QUARTER_TURN;
				end
			end else begin
				cx_q  <= xs;
				cy_q  <= ys;
				acc_q <= '0;
			end
		end
		if (cmd.cordic) begin
			if (cy_q >= 0) begin
				cx_q  <= cx_q + dx;
				cy_q  <= cy_q - dy;
				acc_q <= acc_q + tv;
			end else begin
				cx_q  <= cx_q - dx;
				cy_q  <= cy_q + dy;
				acc_q <= acc_q - tv;
			end
			if (cmd.cnt == '0)
				xsq_q <= x_q * x_q;
			if (cmd.cnt == BIN_W'(1))
				r2_q <= R2W'(xsq_q) + R2W'(ysq);
		end
		if (cmd.bin_calc) begin
			span_q <= sts.span_out;
			prod_q <= PROD_W'(acc_off[ANG_W-1:0]) * PROD_W'(BINS_PER_TURN);
		end
		if (cmd.mem_upd && op_q) begin
			filled_q <= !oob && hit;
			rem_q    <= SW'(rd_q[R2W-1:0]);
			res_q    <= '0;
		end
		if (cmd.sqrt_step) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + sq_bit;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	// result register
	logic [EXTW-1:0] res_ext;
	assign res_ext = EXTW'(res_q[COORD_BITS-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			bin_filled <= op_q && filled_q;
			if (op_q) begin
				status   <= ST_OK;
				bin      <= idx_q;
				range_mm <= filled_q ? res_ext[RANGE_W-1:0] : EMPTY_RANGE;
			end else begin
				range_mm <= '0;
				if (!pv_q) begin
					status <= ST_INVALID;
					bin    <= '0;
				end else if (span_q) begin
					status <= ST_SPAN;
					bin    <= '0;
				end else begin
					status <= ST_OK;
					bin    <= bin_cl;
				end
			end
		end
	end

endmodule

FILE: rtl/point_to_laser_scan_binner_unit.sv
// ----------------------------------------------------------------------------
// point_to_laser_scan_binner_unit
// Bins points by bearing into 0.2 degree cells, keeps nearest or farthest
// range per cell, and reads a cell back as a range with read-and-clear.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid/in_ready   | op, x_mm, y_mm, point_valid, bin_index
//  out     | out_valid/out_ready | status, bin, range_mm, bin_filled
//  cfg     | cfg_we              | cfg_wdata (keep_nearest)
//
// one item at a time: an add goes through idle, 30 cordic iterations, bin
// multiply, memory read, update and result load, skipping read and update
// when out of span; a read goes through memory read, update and one sqrt
// iteration per result bit; an invalid point goes straight to result load.
// after reset a clearing sweep over all 1620 bins empties the bin memory;
// no item is taken meanwhile. a result held by out_ready does not stop the
// next item's transfer; that item then waits at result load, blocking input.
// ----------------------------------------------------------------------------
module point_to_laser_scan_binner_unit import ptls_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic signed [COORD_BITS-1:0] x_mm,
	input  logic signed [COORD_BITS-1:0] y_mm,
	input  logic                         point_valid,
	input  logic [BIN_W-1:0]             bin_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [BIN_W-1:0]             bin,
	output logic [RANGE_W-1:0]           range_mm,
	output logic                         bin_filled
);

	ptls_cmd_t cmd;
	ptls_sts_t sts;

	ptls_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_op          (op),
		.in_point_valid (point_valid),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sts            (sts),
		.cmd            (cmd)
	);

	ptls_dp #(.COORD_BITS(COORD_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.op          (op),
		.x_mm        (x_mm),
		.y_mm        (y_mm),
		.point_valid (point_valid),
		.bin_index   (bin_index),
		.status      (status),
		.bin         (bin),
		.range_mm    (range_mm),
		.bin_filled  (bin_filled)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while previous still in work");

	a_reject_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> range_mm == '0 && !bin_filled && bin == '0)
		else $error("rejected point carries nonzero fields");

	a_filled_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bin_filled |-> status == ST_OK)
		else $error("filled flag on a rejected item");

endmodule
